FILE: rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, constants and helper functions for the speech command
// stream parser.
// ----------------------------------------------------------------------------
package scp_pkg;

    // Field widths
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned PARAM_W     = 16;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned LEVEL_W     = 4;
    localparam int unsigned SETTING_W   = 8;
    localparam int unsigned SIGN_W      = 2;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned TDATA_W     = 48;
    localparam int unsigned TUSER_W     = KIND_W;

    // Default digit limit of one command sequence (1..15)
    localparam int unsigned MAX_DIGITS_DEF = 15;

    // Result queue depth, power of two
    localparam int unsigned FIFO_DEPTH = 4;

    // Reset values
    localparam logic [DATA_W-1:0]  STOP_CODE_RST    = 8'd24;
    localparam logic [DATA_W-1:0]  COMMAND_CODE_RST = 8'd1;
    localparam logic [DATA_W-1:0]  LETTER_RST       = 8'd32;
    localparam logic [LEVEL_W-1:0] LEVEL_RST        = 4'd5;

    // Level limits and scaling
    localparam logic [LEVEL_W-1:0] PITCH_TOP   = 4'd10;
    localparam logic [LEVEL_W-1:0] RATE_TOP    = 4'd9;
    localparam int                 PITCH_MID   = 5;
    localparam int                 PITCH_STEP  = 20;
    localparam int                 RATE_STEP   = 22;
    localparam int                 RATE_OFFSET = 100;

    localparam logic [PARAM_W-1:0] PARAM_MAX = 16'hFFFF;

    // Characters
    localparam logic [DATA_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [DATA_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [DATA_W-1:0] CHAR_0     = 8'h30;
    localparam logic [DATA_W-1:0] CHAR_9     = 8'h39;
    localparam logic [DATA_W-1:0] CHAR_I     = 8'h69;
    localparam logic [DATA_W-1:0] CHAR_P     = 8'h70;
    localparam logic [DATA_W-1:0] CHAR_S     = 8'h73;

    localparam logic signed [SIGN_W-1:0] SIGN_NONE = 2'sd0;
    localparam logic signed [SIGN_W-1:0] SIGN_UP   = 2'sd1;
    localparam logic signed [SIGN_W-1:0] SIGN_DOWN = -2'sd1;

    typedef enum logic [KIND_W-1:0] {
        TOK_TEXT  = 3'd0,
        TOK_INDEX = 3'd1,
        TOK_SPEAK = 3'd2,
        TOK_STOP  = 3'd3,
        TOK_CMD   = 3'd4
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_SIGN   = 2'd1,
        MODE_DIGITS = 2'd2
    } parse_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STOP_CODE    = 1'b0,
        CFG_COMMAND_CODE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        token_kind_t                    kind;
        logic [DATA_W-1:0]              text;
        logic [DATA_W-1:0]              letter;
        logic [PARAM_W-1:0]             param;
        logic signed [SIGN_W-1:0]       sign;
        logic signed [SETTING_W-1:0]    setting;
        logic                           last;
    } result_t;

    // Up to two results caused by one word
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } emit_t;

    function automatic result_t mk_result(
        input token_kind_t                 kind,
        input logic [DATA_W-1:0]           text,
        input logic [DATA_W-1:0]           letter,
        input logic [PARAM_W-1:0]          param,
        input logic signed [SIGN_W-1:0]    sign,
        input logic signed [SETTING_W-1:0] setting
    );
        result_t r;
        r.kind    = kind;
        r.text    = text;
        r.letter  = letter;
        r.param   = param;
        r.sign    = sign;
        r.setting = setting;
        r.last    = 1'b0;
        return r;
    endfunction

    // accum * 10 + digit, saturating
    function automatic logic [PARAM_W-1:0] add_digit(
        input logic [PARAM_W-1:0] accum,
        input logic [DATA_W-1:0]  digit
    );
        logic [PARAM_W+3:0] v;
        v = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0}
            + {{PARAM_W{1'b0}}, digit[3:0]};
        return (v > {4'b0000, PARAM_MAX}) ? PARAM_MAX : v[PARAM_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] new_level(
        input logic [LEVEL_W-1:0]       level,
        input logic [PARAM_W-1:0]       param,
        input logic signed [SIGN_W-1:0] sign,
        input logic [LEVEL_W-1:0]       top
    );
        logic [PARAM_W:0]    sum;
        logic [LEVEL_W-1:0]  res;
        sum = {{(PARAM_W+1-LEVEL_W){1'b0}}, level} + {1'b0, param};
        if (sign != SIGN_NONE && param != '0) begin
            if (sign[SIGN_W-1]) begin
                if ({{(PARAM_W-LEVEL_W){1'b0}}, level} < param) begin
                    res = '0;
                end else begin
                    res = level - param[LEVEL_W-1:0];
                end
            end else begin
                res = (sum > {{(PARAM_W+1-LEVEL_W){1'b0}}, top}) ? top
                                                                 : sum[LEVEL_W-1:0];
            end
        end else begin
            res = (param > {{(PARAM_W-LEVEL_W){1'b0}}, top}) ? top
                                                              : param[LEVEL_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [SETTING_W-1:0] pitch_setting(
        input logic [LEVEL_W-1:0] level
    );
        int v;
        v = (int'(level) - PITCH_MID) * PITCH_STEP;
        return v[SETTING_W-1:0];
    endfunction

    function automatic logic signed [SETTING_W-1:0] rate_setting(
        input logic [LEVEL_W-1:0] level
    );
        int v;
        v = int'(level) * RATE_STEP - RATE_OFFSET;
        return v[SETTING_W-1:0];
    endfunction

endpackage

FILE: rtl/speech_command_stream_parser_core.sv
// ----------------------------------------------------------------------------
// speech_command_stream_parser_core
// Byte stream parser for a speech synthesizer link: text, stop, index mark,
// speak and command tokens.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle on the s_ stream while s_tready is high and
// returns token words on the m_ stream. A byte is decoded in the cycle it is
// accepted, against the parse state, and its one or two tokens land in a
// four-entry result queue, registered, and reach m_ behind any tokens still
// queued. With a ready consumer the block sustains one byte per cycle for
// bytes that give at most one token. For a byte that gives two tokens (speak
// before a command, or a chunk-end flush after a text byte or index mark)
// the m_ port draining one token per cycle sets the rate: s_tready drops
// whenever the queue has fewer than two free entries. Bytes that give no
// token (command byte, sign, digits) are absorbed at one per cycle while
// s_tready is high. The stop and command codes are written through the cfg_
// port, index 0 and 1, and take effect for the next byte; write them only
// while the stream is idle. s_tlast marks the last byte of a read chunk and
// flushes pending text; m_tlast marks the last token of a byte.
// ----------------------------------------------------------------------------
module speech_command_stream_parser_core #(
    parameter int unsigned MAX_DIGITS = scp_pkg::MAX_DIGITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // byte stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scp_pkg::DATA_W-1:0]        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // chunk_end

    // token stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] text_byte, [15:8] command_letter, [31:16] command_param,
    // [33:32] param_sign, [41:34] setting_value, [47:42] zero
    output logic [scp_pkg::TDATA_W-1:0]       m_tdata,
    output logic [scp_pkg::TUSER_W-1:0]       m_tuser,   // [2:0] token_kind
    output logic                              m_tlast,   // last_of_run

    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [scp_pkg::DATA_W-1:0]        cfg_data
);
    import scp_pkg::*;

    logic [DATA_W-1:0] stop_code_reg;
    logic [DATA_W-1:0] command_code_reg;

    logic              s_accept;
    logic              m_accept;
    logic              has_room;
    logic              not_empty;
    emit_t             emit;
    result_t           head;

    assign s_tready = has_room;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_code_reg    <= STOP_CODE_RST;
            command_code_reg <= COMMAND_CODE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_STOP_CODE:    stop_code_reg    <= cfg_data;
                CFG_COMMAND_CODE: command_code_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Decode of the accepted byte against the parse state
    scp_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .data_byte    (s_tdata),
        .chunk_end    (s_tlast),
        .stop_code    (stop_code_reg),
        .command_code (command_code_reg),
        .emit         (emit)
    );

    // Result queue: decouples m_tready from s_tready
    scp_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_data (emit),
        .pop       (m_accept),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign m_tvalid = not_empty;
    assign m_tdata  = {{(TDATA_W - SETTING_W - SIGN_W - PARAM_W - 2*DATA_W){1'b0}},
                       head.setting, head.sign, head.param, head.letter, head.text};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule

FILE: rtl/scp_parser.sv
// ----------------------------------------------------------------------------
// scp_parser
// Parse state and one-word decode: updates the state on an accepted word
// and forms the up to two result words it causes.
// ----------------------------------------------------------------------------
module scp_parser #(
    parameter int unsigned MAX_DIGITS = scp_pkg::MAX_DIGITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [scp_pkg::DATA_W-1:0]    data_byte,
    input  logic                          chunk_end,
    input  logic [scp_pkg::DATA_W-1:0]    stop_code,
    input  logic [scp_pkg::DATA_W-1:0]    command_code,
    output scp_pkg::emit_t                emit
);
    import scp_pkg::*;

    parse_mode_t                 mode_reg,        mode_next;
    logic signed [SIGN_W-1:0]    sign_reg,        sign_next;
    logic [COUNT_W-1:0]          count_reg,       count_next;
    logic [PARAM_W-1:0]          accum_reg,       accum_next;
    logic [DATA_W-1:0]           last_letter_reg, last_letter_next;
    logic [PARAM_W-1:0]          last_param_reg,  last_param_next;
    logic                        pending_reg,     pending_next;
    logic [LEVEL_W-1:0]          rate_reg,        rate_next;
    logic [LEVEL_W-1:0]          pitch_reg,       pitch_next;

    logic                        is_digit;
    logic                        digit_ok;
    logic [PARAM_W-1:0]          acc_added;
    logic [PARAM_W-1:0]          fin_param;
    logic [DATA_W-1:0]           fin_letter;
    logic [LEVEL_W-1:0]          pitch_new;
    logic [LEVEL_W-1:0]          rate_new;
    logic                        do_finish;
    logic                        pend_mid;
    logic signed [SETTING_W-1:0] setting;
    result_t                     cmd_res;
    result_t                     res_a;
    result_t                     res_b;
    logic [1:0]                  res_cnt;

    assign is_digit  = data_byte inside {[CHAR_0:CHAR_9]};
    assign digit_ok  = is_digit && (count_reg < COUNT_W'(MAX_DIGITS));
    assign acc_added = add_digit(accum_reg, data_byte);

    // No digits: repeat the previous command and parameter
    assign fin_param  = (count_reg != '0) ? accum_reg : last_param_reg;
    assign fin_letter = (count_reg != '0) ? data_byte : last_letter_reg;
    assign pitch_new  = new_level(pitch_reg, fin_param, sign_reg, PITCH_TOP);
    assign rate_new   = new_level(rate_reg, fin_param, sign_reg, RATE_TOP);

    always_comb begin
        mode_next        = mode_reg;
        sign_next        = sign_reg;
        count_next       = count_reg;
        accum_next       = accum_reg;
        last_letter_next = last_letter_reg;
        last_param_next  = last_param_reg;
        rate_next        = rate_reg;
        pitch_next       = pitch_reg;
        pend_mid         = pending_reg;
        do_finish        = 1'b0;
        setting          = '0;
        cmd_res          = result_t'('0);
        res_a            = result_t'('0);
        res_b            = result_t'('0);
        res_cnt          = 2'd0;

        case (mode_reg)
            MODE_SIGN: begin
                if (data_byte == CHAR_PLUS) begin
                    sign_next = SIGN_UP;
                    mode_next = MODE_DIGITS;
                end else if (data_byte == CHAR_MINUS) begin
                    sign_next = SIGN_DOWN;
                    mode_next = MODE_DIGITS;
                end else if (is_digit) begin
                    mode_next  = MODE_DIGITS;
                    accum_next = acc_added;
                    count_next = count_reg + 1'b1;
                end else begin
                    do_finish = 1'b1;
                end
            end
            MODE_DIGITS: begin
                if (digit_ok) begin
                    accum_next = acc_added;
                    count_next = count_reg + 1'b1;
                end else begin
                    do_finish = 1'b1;
                end
            end
            default: begin
                // text mode; stop wins when both codes match
                if (data_byte == stop_code) begin
                    pend_mid = 1'b0;
                    res_a    = mk_result(TOK_STOP, '0, '0, '0, SIGN_NONE, '0);
                    res_cnt  = 2'd1;
                end else if (data_byte == command_code) begin
                    mode_next  = MODE_SIGN;
                    sign_next  = SIGN_NONE;
                    count_next = '0;
                    accum_next = '0;
                end else begin
                    pend_mid = 1'b1;
                    res_a    = mk_result(TOK_TEXT, data_byte, '0, '0, SIGN_NONE, '0);
                    res_cnt  = 2'd1;
                end
            end
        endcase

        if (do_finish) begin
            if (count_reg != '0) begin
                last_param_next  = accum_reg;
                last_letter_next = data_byte;
            end
            if (fin_letter == CHAR_I) begin
                res_a   = mk_result(TOK_INDEX, '0, '0, fin_param, sign_reg, '0);
                res_cnt = 2'd1;
            end else begin
                if (fin_letter == CHAR_P) begin
                    pitch_next = pitch_new;
                    setting    = pitch_setting(pitch_new);
                end else if (fin_letter == CHAR_S) begin
                    rate_next = rate_new;
                    setting   = rate_setting(rate_new);
                end
                cmd_res = mk_result(TOK_CMD, '0, fin_letter, fin_param, sign_reg, setting);
                if (pend_mid) begin
                    res_a    = mk_result(TOK_SPEAK, '0, '0, '0, SIGN_NONE, '0);
                    res_b    = cmd_res;
                    res_cnt  = 2'd2;
                    pend_mid = 1'b0;
                end else begin
                    res_a   = cmd_res;
                    res_cnt = 2'd1;
                end
            end
            mode_next  = MODE_TEXT;
            sign_next  = SIGN_NONE;
            count_next = '0;
            accum_next = '0;
        end

        // chunk end flushes pending text; sequence state is kept
        if (chunk_end && pend_mid) begin
            if (res_cnt == 2'd0) begin
                res_a   = mk_result(TOK_SPEAK, '0, '0, '0, SIGN_NONE, '0);
                res_cnt = 2'd1;
            end else begin
                res_b   = mk_result(TOK_SPEAK, '0, '0, '0, SIGN_NONE, '0);
                res_cnt = 2'd2;
            end
            pend_mid = 1'b0;
        end
        pending_next = pend_mid;

        if (res_cnt == 2'd1) begin
            res_a.last = 1'b1;
        end
        if (res_cnt == 2'd2) begin
            res_b.last = 1'b1;
        end
    end

    assign emit.count  = res_cnt;
    assign emit.first  = res_a;
    assign emit.second = res_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_TEXT;
            sign_reg        <= SIGN_NONE;
            count_reg       <= '0;
            accum_reg       <= '0;
            last_letter_reg <= LETTER_RST;
            last_param_reg  <= '0;
            pending_reg     <= 1'b0;
            rate_reg        <= LEVEL_RST;
            pitch_reg       <= LEVEL_RST;
        end else if (accept) begin
            mode_reg        <= mode_next;
            sign_reg        <= sign_next;
            count_reg       <= count_next;
            accum_reg       <= accum_next;
            last_letter_reg <= last_letter_next;
            last_param_reg  <= last_param_next;
            pending_reg     <= pending_next;
            rate_reg        <= rate_next;
            pitch_reg       <= pitch_next;
        end
    end

    ast_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && do_finish |=> mode_reg == MODE_TEXT && count_reg == '0)
        else $error("sequence state not cleared after command letter");

    ast_levels_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pitch_reg <= PITCH_TOP && rate_reg <= RATE_TOP)
        else $error("pitch or rate level out of range");

    ast_chunk_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && chunk_end |=> !pending_reg)
        else $error("text still pending after chunk end");

    ast_digit_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_DIGITS))
        else $error("digit count beyond limit");

endmodule

FILE: rtl/scp_result_fifo.sv
// ----------------------------------------------------------------------------
// scp_result_fifo
// Small result queue: takes up to two result words per cycle, hands out one.
// ----------------------------------------------------------------------------
module scp_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  scp_pkg::emit_t    push_data,
    input  logic              pop,
    output scp_pkg::result_t  head,
    output logic              not_empty,
    output logic              has_room
);
    import scp_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [1:0]         push_n;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign push_n       = push ? push_data.count : 2'd0;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign count_next   = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign has_room  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_data.first;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push_data.second;
        end
    end

    ast_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

endmodule
